// ===== src/sqa_pkg.sv =====
package sqa_pkg;

  // operation codes carried by each transaction
  typedef enum logic [3:0] {
    OP_ADD        = 4'd0,
    OP_SUB        = 4'd1,
    OP_ABS16      = 4'd2,
    OP_MULT       = 4'd3,
    OP_MULT_ROUND = 4'd4,
    OP_DIV16      = 4'd5,
    OP_LONG_MULT  = 4'd6,
    OP_LONG_ADD   = 4'd7,
    OP_LONG_SUB   = 4'd8,
    OP_NORM       = 4'd9,
    OP_LONG_ABS   = 4'd10
  } op_e;

  localparam int unsigned DIV_STEPS  = 15;
  localparam int unsigned QW         = 15;

  localparam logic [31:0] Q15_MAX    = 32'h0000_7fff;
  localparam logic [31:0] Q15_MIN    = 32'hffff_8000;
  localparam logic [31:0] Q31_MAX    = 32'h7fff_ffff;
  localparam logic [31:0] Q31_MIN    = 32'h8000_0000;
  localparam logic [31:0] PROD_MAX   = 32'h4000_0000;
  localparam logic [32:0] ROUND_HALF = 33'd16384;

  // data handed from one cell to the next
  typedef struct packed {
    op_e              op;
    logic [31:0]      res;      // final value, or raw product for multiplies
    logic             err;
    logic             div_run;  // divide still producing quotient bits
    logic [QW-1:0]    rem;
    logic [QW-1:0]    den;
    logic [QW-1:0]    quo;
  } payload_t;

endpackage

// ===== src/sqa_front.sv =====
module sqa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [3:0]        opcode_i,
  input  logic [31:0]       operand_a_i,
  input  logic [31:0]       operand_b_i,
  output logic              valid_o,
  input  logic              ready_i,
  output sqa_pkg::payload_t data_o
);
  import sqa_pkg::*;

  logic             valid_q;
  payload_t         data_q;
  payload_t         data_d;

  logic signed [15:0] a16;
  logic signed [15:0] b16;
  logic signed [16:0] s16;
  logic signed [16:0] d16;
  logic signed [32:0] s32;
  logic signed [32:0] d32;
  logic signed [31:0] prod;
  logic [31:0]        nx;
  logic [4:0]         nrm;

  assign a16  = operand_a_i[15:0];
  assign b16  = operand_b_i[15:0];
  assign s16  = {a16[15], a16} + {b16[15], b16};
  assign d16  = {a16[15], a16} - {b16[15], b16};
  assign s32  = {operand_a_i[31], operand_a_i} + {operand_b_i[31], operand_b_i};
  assign d32  = {operand_a_i[31], operand_a_i} - {operand_b_i[31], operand_b_i};
  assign prod = a16 * b16;
  assign nx   = operand_a_i[31] ? ~operand_a_i : operand_a_i;

  // leading sign count: highest bit that differs from the sign wins
  always_comb begin
    nrm = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (nx[i]) begin
        nrm = 5'(30 - i);
      end
    end
    if (operand_a_i == 32'hffff_ffff) begin
      nrm = 5'd31;
    end
  end

  // operation decode
  always_comb begin
    data_d         = '0;
    data_d.op      = op_e'(opcode_i);
    data_d.rem     = a16[QW-1:0];
    data_d.den     = b16[QW-1:0];
    case (op_e'(opcode_i))
      OP_ADD: begin
        if (s16[16] != s16[15]) data_d.res = s16[16] ? Q15_MIN : Q15_MAX;
        else data_d.res = {{16{s16[15]}}, s16[15:0]};
      end
      OP_SUB: begin
        if (d16[16] != d16[15]) data_d.res = d16[16] ? Q15_MIN : Q15_MAX;
        else data_d.res = {{16{d16[15]}}, d16[15:0]};
      end
      OP_ABS16: begin
        if (a16 == 16'sh8000) data_d.res = Q15_MAX;
        else if (a16[15]) data_d.res = {16'd0, 16'(-a16)};
        else data_d.res = {16'd0, a16};
      end
      OP_MULT, OP_MULT_ROUND, OP_LONG_MULT: begin
        data_d.res = prod;
      end
      OP_DIV16: begin
        if (a16 > b16 || a16[15] || b16[15] || b16 == 16'sd0) begin
          data_d.err = 1'b1;
        end else if (a16 == 16'sd0) begin
          data_d.res = '0;
        end else if (a16 == b16) begin
          data_d.res = Q15_MAX;
        end else begin
          data_d.div_run = 1'b1;
        end
      end
      OP_LONG_ADD: begin
        if (s32[32] != s32[31]) data_d.res = s32[32] ? Q31_MIN : Q31_MAX;
        else data_d.res = s32[31:0];
      end
      OP_LONG_SUB: begin
        if (d32[32] != d32[31]) data_d.res = d32[32] ? Q31_MIN : Q31_MAX;
        else data_d.res = d32[31:0];
      end
      OP_NORM: begin
        data_d.res = {27'd0, nrm};
      end
      OP_LONG_ABS: begin
        if (operand_a_i == Q31_MIN) data_d.res = Q31_MAX;
        else if (operand_a_i[31]) data_d.res = -operand_a_i;
        else data_d.res = operand_a_i;
      end
      default: begin
        data_d.res = '0;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/sqa_cell.sv =====
module sqa_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  sqa_pkg::payload_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output sqa_pkg::payload_t data_o
);
  import sqa_pkg::*;

  logic          valid_q;
  payload_t      data_q;
  payload_t      data_d;
  logic [QW:0]   rem2;
  logic [QW:0]   diff;

  assign rem2 = {data_i.rem, 1'b0};
  assign diff = rem2 - {1'b0, data_i.den};

  // one restoring divide step
  always_comb begin
    data_d = data_i;
    if (data_i.div_run) begin
      if (rem2 >= {1'b0, data_i.den}) begin
        data_d.rem = diff[QW-1:0];
        data_d.quo = {data_i.quo[QW-2:0], 1'b1};
      end else begin
        data_d.rem = rem2[QW-1:0];
        data_d.quo = {data_i.quo[QW-2:0], 1'b0};
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/saturating_q15_q31_alu.sv =====
// Saturating Q15/Q31 ALU. One transaction in, one transaction out, in order.
// A transaction is taken every cycle while the output side keeps up. The path
// is an operand decode and multiply register, a row of 15 divide cells that
// each produce one quotient bit, and an output register that applies
// multiply rounding and saturation. Every operation travels the full row, so
// results never reorder. Bubbles in the row are closed up while the output is
// stalled, and in_stall_o rises only once every stage is occupied.
module saturating_q15_q31_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  opcode_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_value_o,
  output logic        op_error_o
);
  import sqa_pkg::*;

  logic     stg_valid [DIV_STEPS+1];
  logic     stg_ready [DIV_STEPS+1];
  payload_t stg_data  [DIV_STEPS+1];
  logic     front_ready;

  logic        out_valid_q;
  logic        out_ready;
  logic [31:0] res_q;
  logic [31:0] res_d;
  logic        err_q;
  op_e         op_q;
  payload_t    fin;
  logic [32:0] rnd;
  logic [17:0] rnd_sh;

  // decode, saturating add/sub/abs, multiply, normalize, divide checks
  sqa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .ready_o     (front_ready),
    .opcode_i    (opcode_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .valid_o     (stg_valid[0]),
    .ready_i     (stg_ready[0]),
    .data_o      (stg_data[0])
  );

  assign in_stall_o = !front_ready;

  // row of divide cells
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_cell
    sqa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[k-1]),
      .ready_o (stg_ready[k-1]),
      .data_i  (stg_data[k-1]),
      .valid_o (stg_valid[k]),
      .ready_i (stg_ready[k]),
      .data_o  (stg_data[k])
    );
  end

  assign fin                  = stg_data[DIV_STEPS];
  assign out_ready            = !out_valid_q || !out_stall_i;
  assign stg_ready[DIV_STEPS] = out_ready;

  // multiply rounding and final select
  assign rnd    = {fin.res[31], fin.res} + ROUND_HALF;
  assign rnd_sh = rnd[32:15];

  always_comb begin
    case (fin.op)
      OP_MULT: begin
        if (fin.res == PROD_MAX) res_d = Q15_MAX;
        else res_d = {{15{fin.res[31]}}, fin.res[31:15]};
      end
      OP_MULT_ROUND: begin
        if (!rnd_sh[17] && rnd_sh[16:15] != 2'b00) res_d = Q15_MAX;
        else res_d = {{14{rnd_sh[17]}}, rnd_sh};
      end
      OP_LONG_MULT: begin
        if (fin.res == PROD_MAX) res_d = Q31_MAX;
        else res_d = {fin.res[30:0], 1'b0};
      end
      OP_DIV16: begin
        if (fin.div_run) res_d = {{(32-QW){1'b0}}, fin.quo};
        else res_d = fin.res;
      end
      default: begin
        res_d = fin.res;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= stg_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && stg_valid[DIV_STEPS]) begin
      res_q <= res_d;
      err_q <= fin.err;
      op_q  <= fin.op;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign op_error_o     = err_q;

  // an error result always reads zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && op_error_o |-> result_value_o == 32'd0)
    else $error("error transaction with nonzero result");

  // only a divide can flag an error
  a_err_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && op_error_o |-> op_q == OP_DIV16)
    else $error("error flag on a non-divide transaction");

  // an empty output register lets the whole row advance
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("input stalled while output register empty");

  // a divide result never exceeds one in Q15
  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && op_q == OP_DIV16 |-> result_value_o <= Q15_MAX)
    else $error("divide result out of range");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import sqa_pkg::*;

  // saturation bounds and rounding offset in wide signed arithmetic
  localparam longint Q15_HI   = 64'sd32767;
  localparam longint Q15_LO   = -64'sd32768;
  localparam longint Q31_HI   = 64'sd2147483647;
  localparam longint Q31_LO   = -64'sd2147483648;
  localparam longint RND_HALF = 64'sd16384;

  // opcodes with no operation behind them
  localparam logic [3:0] OP_SPARE_LO = 4'd11;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;

  localparam int RANDOM_OPS = 1200;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [3:0]  opc;
    logic [31:0] a;
    logic [31:0] b;
    bit          drain_first;
  } alu_item_t;

  typedef struct {
    logic [31:0] value;
    logic        err;
  } alu_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [3:0]  opcode_i = '0;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] result_value_o;
  logic        op_error_o;

  alu_item_t   pending_ops[$];
  alu_result_t awaited_results[$];
  int          error_count = 0;
  int          in_gap = 0;
  int          in_steady = 0;
  int          out_hold = 0;
  int          out_steady = 0;

  saturating_q15_q31_alu u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .operand_a_i    (operand_a_i),
    .operand_b_i    (operand_b_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .op_error_o     (op_error_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  function automatic longint clip16(longint x);
    if (x > Q15_HI) return Q15_HI;
    if (x < Q15_LO) return Q15_LO;
    return x;
  endfunction

  function automatic longint clip32(longint x);
    if (x > Q31_HI) return Q31_HI;
    if (x < Q31_LO) return Q31_LO;
    return x;
  endfunction

  // expected value and error flag for one operation
  function automatic alu_result_t predict_alu(logic [3:0] opc, logic [31:0] a,
                                              logic [31:0] b);
    longint      a16, b16, a32, b32, val, quo, rem;
    logic [31:0] mag;
    int          shifts;
    alu_result_t res;
    a16 = $signed(a[15:0]);
    b16 = $signed(b[15:0]);
    a32 = $signed(a);
    b32 = $signed(b);
    val = 0;
    res.err = 1'b0;
    case (opc)
      OP_ADD: val = clip16(a16 + b16);
      OP_SUB: val = clip16(a16 - b16);
      OP_ABS16: val = (a16 == Q15_LO) ? Q15_HI : ((a16 < 0) ? -a16 : a16);
      OP_MULT: begin
        if (a16 == Q15_LO && b16 == Q15_LO) val = Q15_HI;
        else val = (a16 * b16) >>> 15;
      end
      OP_MULT_ROUND: begin
        if (a16 == Q15_LO && b16 == Q15_LO) val = Q15_HI;
        else val = clip16((a16 * b16 + RND_HALF) >>> 15);
      end
      OP_DIV16: begin
        if (a16 > b16 || a16 < 0 || b16 <= 0) begin
          res.err = 1'b1;
        end else if (a16 == b16) begin
          val = Q15_HI;
        end else if (a16 != 0) begin
          // restoring division, one quotient bit per step
          quo = 0;
          rem = a16;
          for (int i = 0; i < DIV_STEPS; i++) begin
            quo = quo << 1;
            rem = rem << 1;
            if (rem >= b16) begin
              rem = rem - b16;
              quo = quo + 1;
            end
          end
          val = quo;
        end
      end
      OP_LONG_MULT: val = clip32(a16 * b16 * 2);
      OP_LONG_ADD: val = clip32(a32 + b32);
      OP_LONG_SUB: val = clip32(a32 - b32);
      OP_NORM: begin
        mag = a;
        if (mag == '0) begin
          val = 0;
        end else if (&mag) begin
          val = 31;
        end else begin
          if (mag[31]) mag = ~mag;
          shifts = 0;
          while (mag < 32'h4000_0000) begin
            mag = mag << 1;
            shifts++;
          end
          val = shifts;
        end
      end
      OP_LONG_ABS: val = (a32 == Q31_LO) ? Q31_HI : ((a32 < 0) ? -a32 : a32);
      default: val = 0;
    endcase
    res.value = val[31:0];
    return res;
  endfunction

  // idle length: mostly short, a few long, with runs of no idling
  function automatic int idle_len(inout int steady);
    int r;
    if (steady > 0) begin
      steady--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      steady = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // operand mix: full random, small, edge words, edge low halves, shifted
  function automatic logic [31:0] rand_operand();
    logic [31:0] w;
    logic [15:0] lo;
    int          s;
    w = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return w;
      4: begin
        s = $urandom_range(0, 32);
        s = s - 16;
        lo = s[15:0];
        return {w[31:16], lo};
      end
      5: begin
        case ($urandom_range(0, 5))
          0: lo = 16'h0000;
          1: lo = 16'h0001;
          2: lo = 16'h7fff;
          3: lo = 16'h8000;
          4: lo = 16'h8001;
          default: lo = 16'hffff;
        endcase
        return {w[31:16], lo};
      end
      6: begin
        case ($urandom_range(0, 9))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'h7fff_ffff;
          3: return 32'h8000_0000;
          4: return 32'h8000_0001;
          5: return 32'hffff_ffff;
          6: return 32'h0000_7fff;
          7: return 32'hffff_8000;
          8: return 32'h4000_0000;
          default: return 32'h3fff_ffff;
        endcase
      end
      7: begin
        s = $urandom_range(0, 64);
        s = s - 32;
        return s;
      end
      default: begin
        w = w >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) w = ~w;
        return w;
      end
    endcase
  endfunction

  task automatic add_op(logic [3:0] opc, logic [31:0] a, logic [31:0] b,
                        bit drain_first = 1'b0);
    alu_item_t it;
    it.opc = opc;
    it.a = a;
    it.b = b;
    it.drain_first = drain_first;
    pending_ops.push_back(it);
  endtask

  // driver: record accepted transactions, present the next pending one
  always @(posedge clk_i) begin
    logic      fire;
    alu_item_t cur;
    if (rst_ni) begin
      fire = in_valid_i && !in_stall_o;
      if (fire) begin
        awaited_results.push_back(predict_alu(opcode_i, operand_a_i, operand_b_i));
        in_gap = idle_len(in_steady);
      end
      if (!in_valid_i || fire) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() != 0 &&
                     (!pending_ops[0].drain_first || awaited_results.size() == 0)) begin
          cur = pending_ops.pop_front();
          in_valid_i  <= 1'b1;
          opcode_i    <= cur.opc;
          operand_a_i <= cur.a;
          operand_b_i <= cur.b;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    alu_result_t exp_res;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result value=%h err=%b", $time,
                   result_value_o, op_error_o);
          error_count++;
        end else begin
          exp_res = awaited_results.pop_front();
          if (result_value_o !== exp_res.value) begin
            $display("%0t: result_value expected %h actual %h", $time,
                     exp_res.value, result_value_o);
            error_count++;
          end
          if (op_error_o !== exp_res.err) begin
            $display("%0t: op_error expected %b actual %b", $time,
                     exp_res.err, op_error_o);
            error_count++;
          end
        end
      end
      // receiver stall pattern
      if (out_hold > 0) begin
        out_hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        out_hold = idle_len(out_steady);
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [3:0]  opc;
    logic [31:0] a, b;
    logic [15:0] num, den;
    int          r;

    // directed: saturation edges, special cases of every operation
    add_op(OP_ADD,       32'hdead_7fff, 32'h1234_0001);
    add_op(OP_ADD,       32'h0000_8000, 32'hffff_ffff);
    add_op(OP_SUB,       32'h0000_8000, 32'h0000_0001);
    add_op(OP_SUB,       32'h0000_7fff, 32'hffff_ffff);
    add_op(OP_ABS16,     32'h5555_8000, 32'hffff_ffff);
    add_op(OP_ABS16,     32'h0000_fffb, 32'h0000_0000);
    add_op(OP_MULT,      32'h0000_8000, 32'hffff_8000);
    add_op(OP_MULT,      32'hffff_ffff, 32'h0000_0001);
    add_op(OP_MULT_ROUND, 32'h0000_8000, 32'h0000_8000);
    add_op(OP_MULT_ROUND, 32'h0000_7fff, 32'h0000_7fff);
    add_op(OP_DIV16,     32'h0000_ffff, 32'h0000_0004);
    add_op(OP_DIV16,     32'h0000_0001, 32'h0000_fff0);
    add_op(OP_DIV16,     32'h0000_0009, 32'h0000_0003);
    add_op(OP_DIV16,     32'h0000_0000, 32'h0000_0000);
    add_op(OP_DIV16,     32'hffff_1234, 32'h0000_1234);
    add_op(OP_DIV16,     32'h0000_0000, 32'h0000_7fff);
    add_op(OP_DIV16,     32'h0000_0001, 32'h0000_0003);
    add_op(OP_LONG_MULT, 32'h0000_8000, 32'h0000_8000);
    add_op(OP_LONG_ADD,  32'h7fff_ffff, 32'h0000_0001);
    add_op(OP_LONG_SUB,  32'h8000_0000, 32'h0000_0001);
    add_op(OP_NORM,      32'h0000_0000, 32'hffff_ffff);
    add_op(OP_NORM,      32'hffff_ffff, 32'h0000_0000);
    add_op(OP_NORM,      32'h0000_0001, 32'h0000_0000);
    add_op(OP_LONG_ABS,  32'h8000_0000, 32'h7fff_ffff);
    add_op(OP_LONG_ABS,  32'hffff_fff9, 32'h0000_0000);
    add_op(OP_SPARE_LO,  32'h7fff_ffff, 32'h8000_0000);
    add_op(OP_SPARE_HI,  32'hffff_ffff, 32'hffff_ffff);

    // random: mostly real operations, some spare opcodes
    for (int i = 0; i < RANDOM_OPS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) opc = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      else opc = 4'($urandom_range(OP_ADD, OP_LONG_ABS));
      a = rand_operand();
      b = rand_operand();
      // divides mostly get a valid numerator/divisor pair
      if (opc == OP_DIV16 && $urandom_range(0, 9) < 8) begin
        den = 16'($urandom_range(1, 32767));
        if ($urandom_range(0, 7) == 0) num = den;
        else num = 16'($urandom_range(0, den));
        a[15:0] = num;
        b[15:0] = den;
      end
      add_op(opc, a, b, (i == 400 || i == 900));
    end

    // reset
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // wait for all transactions to be accepted and answered
    while (pending_ops.size() != 0 || in_valid_i) @(negedge clk_i);
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (error_count == 0) begin
      $display("saturating_q15_q31_alu regression: pass");
    end else begin
      $display("saturating_q15_q31_alu regression: fail");
    end
    $finish;
  end

  // timeout
  initial begin
    #10_000_000;
    $display("saturating_q15_q31_alu regression: fail");
    $finish;
  end

endmodule
